>>> design/aes128enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 encryption package
// S-box table, GF(2^8) helpers, round functions and the controller commands.
// ----------------------------------------------------------------------------
package aes128enc_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int ROUND_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd1;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd10;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
        logic capture;
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] col_mix(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Byte (c, r) of the state sits at bits [127 - 8*(4c + r) -: 8].
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] state_mix(input logic [BLOCK_W-1:0] s);
        return {col_mix(s[127:96]), col_mix(s[95:64]),
                col_mix(s[63:32]), col_mix(s[31:0])};
    endfunction

    function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] rk,
                                                    input logic [7:0] rc);
        logic [31:0] t, n0, n1, n2, n3;
        t  = subst_word({rk[23:0], rk[31:24]}) ^ {rc, 24'h000000};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

>>> design/aes128enc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 encryption controller
// Sequences the initial key addition and ten rounds and owns both handshakes.
// ----------------------------------------------------------------------------
module aes128enc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aes128enc_pkg::t_cmd o_cmd
);
    import aes128enc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    logic               accept;
    logic               finish;
    logic               step;

    always_comb begin
        finish = (r_state == ST_RUN) && (r_round == LAST_ROUND)
                 && (!r_out_valid || !i_out_stall);
        step   = (r_state == ST_RUN) && ((r_round != LAST_ROUND) || finish);
        accept = i_in_valid && !o_in_stall;

        case (r_state)
            ST_IDLE: n_state = accept ? ST_RUN : ST_IDLE;
            ST_RUN:  n_state = (finish && !accept) ? ST_IDLE : ST_RUN;
            default: n_state = ST_IDLE;
        endcase

        if (accept) begin
            n_round = FIRST_ROUND;
        end else if (step) begin
            n_round = r_round + 1'b1;
        end else begin
            n_round = r_round;
        end

        if (finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= FIRST_ROUND;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state == ST_RUN) && !finish;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = accept;
    assign o_cmd.step    = step;
    assign o_cmd.last    = (r_round == LAST_ROUND);
    assign o_cmd.capture = finish;

endmodule

>>> design/aes128enc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 encryption datapath
// Key registers, shared round unit with on-the-fly key schedule, output register.
// ----------------------------------------------------------------------------
module aes128enc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [aes128enc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_cfg_wdata,
    input  aes128enc_pkg::t_cmd                 i_cmd,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_upper,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_lower,
    output logic [aes128enc_pkg::HALF_W-1:0]    o_cipher_upper,
    output logic [aes128enc_pkg::HALF_W-1:0]    o_cipher_lower
);
    import aes128enc_pkg::*;

    logic [HALF_W-1:0]  r_key_upper;
    logic [HALF_W-1:0]  r_key_lower;
    logic [BLOCK_W-1:0] r_block;
    logic [BLOCK_W-1:0] r_rkey;
    logic [7:0]         r_rcon;
    logic [BLOCK_W-1:0] r_cipher;
    logic [BLOCK_W-1:0] n_rkey;
    logic [BLOCK_W-1:0] n_block;
    logic [BLOCK_W-1:0] shifted;

    always_comb begin
        n_rkey  = key_step(r_rkey, r_rcon);
        shifted = sub_shift(r_block);
        n_block = (i_cmd.last ? shifted : state_mix(shifted)) ^ n_rkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KEY_UPPER: r_key_upper <= i_cfg_wdata;
                REG_KEY_LOWER: r_key_lower <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block <= {i_plain_upper, i_plain_lower} ^ {r_key_upper, r_key_lower};
            r_rkey  <= {r_key_upper, r_key_lower};
            r_rcon  <= RCON_INIT;
        end else if (i_cmd.step) begin
            r_block <= n_block;
            r_rkey  <= n_rkey;
            r_rcon  <= xtime(r_rcon);
        end
        if (i_cmd.capture) begin
            r_cipher <= n_block;
        end
    end

    assign o_cipher_upper = r_cipher[BLOCK_W-1:HALF_W];
    assign o_cipher_lower = r_cipher[HALF_W-1:0];

endmodule

>>> design/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Forward AES-128 cipher with a key set through two configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     i_in_valid / o_in_stall    i_plain_upper, i_plain_lower
//  output    o_out_valid / i_out_stall  o_cipher_upper, o_cipher_lower
//  config    i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// The initial key addition is done in the cycle that accepts a block, and the
// ten rounds then run in the shared round unit, which also derives one round
// key per cycle unless the last round is held by a stalled output; the last
// round writes the ciphertext into the output register. The next block is
// taken in the cycle of the last round, while the previous one is captured.
// Reset is synchronous and active low; the key resets to all zeros.
// While the output register is full and stalled, the last round waits.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [aes128enc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_upper,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_lower,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aes128enc_pkg::HALF_W-1:0]    o_cipher_upper,
    output logic [aes128enc_pkg::HALF_W-1:0]    o_cipher_lower
);
    import aes128enc_pkg::*;

    t_cmd cmd;

    aes128enc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    aes128enc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .i_plain_upper  (i_plain_upper),
        .i_plain_lower  (i_plain_lower),
        .o_cipher_upper (o_cipher_upper),
        .o_cipher_lower (o_cipher_lower)
    );

endmodule

>>> verif/aes128_block_encrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption checker
// Watches the key register writes and both data channels of the cipher. It
// keeps its own key schedule and S-box, computes the ciphertext of every
// accepted plaintext block and compares each delivered ciphertext, in order,
// with the oldest prediction. It reports the failure count and the number of
// ciphertext blocks still outstanding.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [aes128enc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_upper,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_plain_lower,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_cipher_upper,
    input  logic [aes128enc_pkg::HALF_W-1:0]    i_cipher_lower,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int         KEY_WORDS      = 44;
    localparam int         NUM_ROUNDS     = 10;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [7:0] REDUCTION_POLY = 8'h1b;
    localparam logic [7:0] AFFINE_CONST   = 8'h63;
    localparam logic [7:0] RCON_FIRST     = 8'h01;

    typedef struct packed {
        logic [aes128enc_pkg::HALF_W-1:0] upper;
        logic [aes128enc_pkg::HALF_W-1:0] lower;
    } t_cipher_block;

    logic [7:0]                       sbox_lut [256];
    logic [31:0]                      sched_words [KEY_WORDS];
    logic [aes128enc_pkg::HALF_W-1:0] key_hi;
    logic [aes128enc_pkg::HALF_W-1:0] key_lo;
    t_cipher_block                    expected_ciphers [$];
    t_cipher_block                    oldest;
    int                               fail_total = 0;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? REDUCTION_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_double(x);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        d0 = gf_double(a0);
        d1 = gf_double(a1);
        d2 = gf_double(a2);
        d3 = gf_double(a3);
        return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                a0 ^ d1 ^ d2 ^ a2 ^ a3,
                a0 ^ a1 ^ d2 ^ d3 ^ a3,
                d0 ^ a0 ^ a1 ^ a2 ^ d3};
    endfunction

    function automatic void expand_sched_words();
        logic [31:0] t;
        logic [7:0]  rcon;
        sched_words[0] = key_hi[63:32];
        sched_words[1] = key_hi[31:0];
        sched_words[2] = key_lo[63:32];
        sched_words[3] = key_lo[31:0];
        rcon = RCON_FIRST;
        for (int i = 4; i < KEY_WORDS; i++) begin
            t = sched_words[i - 1];
            if (i % 4 == 0) begin
                t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rcon, 24'h000000};
                rcon = gf_double(rcon);
            end
            sched_words[i] = sched_words[i - 4] ^ t;
        end
    endfunction

    function automatic t_cipher_block encrypt_block(input logic [63:0] upper,
                                                    input logic [63:0] lower);
        logic [31:0]   col [4];
        logic [31:0]   shifted [4];
        t_cipher_block res;
        col[0] = upper[63:32] ^ sched_words[0];
        col[1] = upper[31:0] ^ sched_words[1];
        col[2] = lower[63:32] ^ sched_words[2];
        col[3] = lower[31:0] ^ sched_words[3];
        for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    shifted[c][31 - 8 * r -: 8] = sbox_lut[col[(c + r) % 4][31 - 8 * r -: 8]];
                end
            end
            for (int c = 0; c < 4; c++) begin
                col[c] = ((rnd == NUM_ROUNDS) ? shifted[c] : mix_word(shifted[c]))
                         ^ sched_words[4 * rnd + c];
            end
        end
        res.upper = {col[0], col[1]};
        res.lower = {col[2], col[3]};
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_v, act_v);
        end
    endfunction

    // The S-box is built from the field inverse and the affine map.
    initial begin : build_sbox
        logic [7:0] inv;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            if (v != 0) begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++) begin
                    inv = gf_mul(inv, v[7:0]);
                end
            end
            sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                          ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            expand_sched_words();
            expected_ciphers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ciphers.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: ciphertext %h %h arrived with none pending", $realtime,
                                 i_cipher_upper, i_cipher_lower);
                    end
                end else begin
                    oldest = expected_ciphers.pop_front();
                    if (i_cipher_upper !== oldest.upper) begin
                        note_mismatch("cipher_upper", oldest.upper, i_cipher_upper);
                    end
                    if (i_cipher_lower !== oldest.lower) begin
                        note_mismatch("cipher_lower", oldest.lower, i_cipher_lower);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_ciphers.push_back(encrypt_block(i_plain_upper, i_plain_lower));
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == aes128enc_pkg::REG_KEY_UPPER) begin
                    key_hi = i_cfg_wdata;
                    expand_sched_words();
                end else if (i_cfg_index == aes128enc_pkg::REG_KEY_LOWER) begin
                    key_lo = i_cfg_wdata;
                    expand_sched_words();
                end
            end
        end
        o_pending    <= expected_ciphers.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> verif/tb_aes128_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives key writes and plaintext blocks into the cipher: a directed set of
// edge patterns, partial and ignored key writes, then random blocks under
// changing keys and three idling profiles. A checker beside the block
// predicts and compares every ciphertext; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int KEY_EPOCH       = 100;
    localparam int FLUSH_CYCLES    = 30;

    localparam logic [aes128enc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [aes128enc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [aes128enc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_wdata    = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [63:0] plain_upper  = '0;
    logic [63:0] plain_lower  = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [63:0] cipher_upper;
    logic [63:0] cipher_lower;
    int          fail_count;
    int          pending_count;
    int          cycle_count  = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 57;

    aes128_block_encrypt u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_plain_upper  (plain_upper),
        .i_plain_lower  (plain_lower),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_cipher_upper (cipher_upper),
        .o_cipher_lower (cipher_lower)
    );

    aes128_block_encrypt_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_plain_upper  (plain_upper),
        .i_plain_lower  (plain_lower),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_cipher_upper (cipher_upper),
        .i_cipher_lower (cipher_lower),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] random_half();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // Entered just after a rising edge; returns at the edge that accepts the block.
    task automatic send_block(input logic [63:0] upper, input logic [63:0] lower);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        plain_upper <= upper;
        plain_lower <= lower;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    task automatic wait_all_ciphers();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [aes128enc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic change_key();
        int mode;
        mode = $urandom_range(7);
        wait_all_ciphers();
        case (mode)
            0: begin
                write_reg(aes128enc_pkg::REG_KEY_UPPER, random_half());
            end
            1: begin
                write_reg(aes128enc_pkg::REG_KEY_LOWER, random_half());
            end
            2: begin
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, random_half());
                write_reg(aes128enc_pkg::REG_KEY_LOWER, random_half());
            end
            3: begin
                write_reg(aes128enc_pkg::REG_KEY_UPPER, '1);
                write_reg(aes128enc_pkg::REG_KEY_LOWER, '1);
            end
            4: begin
                write_reg(aes128enc_pkg::REG_KEY_UPPER, '0);
                write_reg(aes128enc_pkg::REG_KEY_LOWER, '0);
            end
            default: begin
                write_reg(aes128enc_pkg::REG_KEY_UPPER, {$urandom, $urandom});
                write_reg(aes128enc_pkg::REG_KEY_LOWER, {$urandom, $urandom});
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The key after reset is all zeros.
        send_block('0, '0);
        send_block('1, '1);
        send_block({1'b1, 63'd0}, 64'd1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        wait_all_ciphers();

        // Only the upper key half changes; the lower half stays zero.
        write_reg(aes128enc_pkg::REG_KEY_UPPER, 64'h0001_0203_0405_0607);
        cfg_wr_en <= 1'b0;
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        wait_all_ciphers();

        write_reg(aes128enc_pkg::REG_KEY_LOWER, 64'h0809_0a0b_0c0d_0e0f);
        cfg_wr_en <= 1'b0;
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_block('0, '0);
        wait_all_ciphers();

        // Writes to unused register indexes must leave the key alone.
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        wait_all_ciphers();

        write_reg(aes128enc_pkg::REG_KEY_UPPER, '1);
        write_reg(aes128enc_pkg::REG_KEY_LOWER, '1);
        cfg_wr_en <= 1'b0;
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
        wait_all_ciphers();

        write_reg(aes128enc_pkg::REG_KEY_UPPER, 64'h2b7e_1516_28ae_d2a6);
        write_reg(aes128enc_pkg::REG_KEY_LOWER, 64'habf7_1588_09cf_4f3c);
        cfg_wr_en <= 1'b0;
        send_block(64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
        send_block('1, '0);
        send_block('0, '1);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 21;
                recv_idle_pct = 57;
            end else if (phase == 1) begin
                send_idle_pct = 57;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % KEY_EPOCH == 0) begin
                    change_key();
                end
                send_block(random_half(), random_half());
            end
        end

        wait_all_ciphers();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/aes128enc_pkg.sv
design/aes128enc_ctrl.sv
design/aes128enc_dp.sv
design/aes128_block_encrypt.sv
verif/aes128_block_encrypt_checker.sv
verif/tb_aes128_block_encrypt.sv
